@@ rtl/ptts_pkg.sv @@
// Shared constants and types for the periodic task tick scheduler.
package ptts_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_W     = 3;
    localparam int TIME_W     = 16;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    // Slot operation broadcast to every cell; sel picks the addressed one
    typedef struct packed {
        logic              create;
        logic              suspend;
        logic              resume;
        logic              remove;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] first_delay;
    } cmd_t;

endpackage

@@ rtl/periodic_task_tick_scheduler.sv @@
// Top level: chain of slot cells, tick token sequencer and result register.
// Create, suspend, resume, delete: status result registered in the cycle after the transaction.
// Tick: a token walks the cell chain one slot per cycle,
// and fire results appear as the token passes; the walk holds while the result waits.
// The next item is taken once the token has left the chain.
// Reset (rst_n, asynchronous, active low) empties and suspends every slot, clears all delays.
module periodic_task_tick_scheduler
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptts_pkg::OP_W-1:0]     opcode,
    input  logic [ptts_pkg::SLOT_W-1:0]   slot,
    input  logic [ptts_pkg::TIME_W-1:0]   period,
    input  logic [ptts_pkg::TIME_W-1:0]   first_delay,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [ptts_pkg::SLOT_W-1:0]   task_slot,
    output logic [ptts_pkg::STATUS_W-1:0] status,
    output logic                          last
);

    localparam int N = ptts_pkg::SLOT_COUNT;

    logic                          out_valid_reg, out_valid_next;
    logic                          kind_reg, kind_next;
    logic [ptts_pkg::SLOT_W-1:0]   task_slot_reg, task_slot_next;
    logic [ptts_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          last_reg, last_next;

    ptts_pkg::cmd_t    cmd;
    logic              adv, busy, accept, in_range, taken, start, is_op;
    logic [N-1:0]      hit, sel, tok, present, due, fire, later;
    logic [N:0]        below;
    logic [ptts_pkg::IDX_W-1:0] fire_idx;

    assign adv      = !out_valid_reg || out_ready;
    assign busy     = |tok;
    assign in_ready = !busy && adv;
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(slot) < N);
    assign start    = accept && (opcode == ptts_pkg::OP_TICK);
    assign is_op    = (opcode == ptts_pkg::OP_CREATE) || (opcode == ptts_pkg::OP_SUSPEND) ||
                      (opcode == ptts_pkg::OP_RESUME) || (opcode == ptts_pkg::OP_DELETE);

    assign cmd.create      = (opcode == ptts_pkg::OP_CREATE);
    assign cmd.suspend     = (opcode == ptts_pkg::OP_SUSPEND);
    assign cmd.resume      = (opcode == ptts_pkg::OP_RESUME);
    assign cmd.remove      = (opcode == ptts_pkg::OP_DELETE);
    assign cmd.period      = period;
    assign cmd.first_delay = first_delay;

    assign below[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            assign hit[gi] = (32'(slot) == gi);
            assign sel[gi] = accept && hit[gi];
            // a cell above the token has not been visited this tick
            assign later[gi] = due[gi] && below[gi];
            ptts_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .sel       (sel[gi]),
                .adv       (adv),
                .tok_in    ((gi == 0) ? start : tok[(gi == 0) ? 0 : gi - 1]),
                .below_in  (below[gi]),
                .tok       (tok[gi]),
                .below_out (below[gi+1]),
                .present   (present[gi]),
                .due       (due[gi])
            );
        end
    endgenerate

    assign fire  = tok & due;
    assign taken = |(present & hit);

    always_comb
    begin
        fire_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (fire[i])
            begin
                fire_idx = fire_idx | ptts_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        task_slot_next = task_slot_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (adv && |fire)
        begin
            out_valid_next = 1'b1;
            kind_next      = ptts_pkg::KIND_FIRE;
            task_slot_next = 3'(fire_idx);
            status_next    = ptts_pkg::ST_OK;
            last_next      = !(|later);
        end
        else if (accept && is_op)
        begin
            out_valid_next = 1'b1;
            kind_next      = ptts_pkg::KIND_STATUS;
            task_slot_next = slot;
            last_next      = 1'b1;
            if (!in_range)
            begin
                status_next = ptts_pkg::ST_RANGE;
            end
            else if (cmd.create && taken)
            begin
                status_next = ptts_pkg::ST_TAKEN;
            end
            else
            begin
                status_next = ptts_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        task_slot_reg <= task_slot_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign task_slot = task_slot_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

@@ rtl/ptts_cell.sv @@
// One task slot of the scheduler chain: flags, period and delay counter.
module ptts_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  ptts_pkg::cmd_t cmd,
    input  logic          sel,
    input  logic          adv,
    input  logic          tok_in,
    input  logic          below_in,
    output logic          tok,
    output logic          below_out,
    output logic          present,
    output logic          due
);

    logic                        present_reg, present_next;
    logic                        resumed_reg, resumed_next;
    logic [ptts_pkg::TIME_W-1:0] period_reg, period_next;
    logic [ptts_pkg::TIME_W-1:0] delay_reg, delay_next;
    logic                        tok_reg, tok_next;
    logic                        zero;

    assign zero      = (delay_reg == '0);
    assign due       = resumed_reg && present_reg && zero;
    assign tok       = tok_reg;
    assign below_out = below_in | tok_reg;
    assign present   = present_reg;

    always_comb
    begin
        present_next = present_reg;
        resumed_next = resumed_reg;
        period_next  = period_reg;
        delay_next   = delay_reg;
        tok_next     = adv ? tok_in : tok_reg;
        if (tok_reg && adv && resumed_reg)
        begin
            // visit on tick: reload when due, count down when nonzero; an empty slot at zero holds
            if (!zero)
            begin
                delay_next = delay_reg - 1'b1;
            end
            else if (present_reg)
            begin
                delay_next = period_reg - 1'b1;
            end
        end
        if (sel)
        begin
            if (cmd.create && !present_reg)
            begin
                present_next = 1'b1;
                resumed_next = 1'b1;
                period_next  = cmd.period;
                delay_next   = cmd.first_delay;
            end
            if (cmd.suspend)
            begin
                resumed_next = 1'b0;
            end
            if (cmd.resume)
            begin
                resumed_next = 1'b1;
            end
            if (cmd.remove)
            begin
                present_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            resumed_reg <= 1'b0;
            period_reg  <= '0;
            delay_reg   <= '0;
            tok_reg     <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            resumed_reg <= resumed_next;
            period_reg  <= period_next;
            delay_reg   <= delay_next;
            tok_reg     <= tok_next;
        end
    end

endmodule

@@ verif/periodic_task_tick_scheduler_tb.sv @@
// Self-checking testbench for the periodic task tick scheduler: slot operations and tick firing.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;

    localparam int MAX_FIRES  = 8;
    localparam int LONG_HOLD  = 300;
    localparam int CYCLE_CAP  = 400000;

    typedef struct packed {
        logic                          kind;
        logic [ptts_pkg::SLOT_W-1:0]   task_slot;
        logic [ptts_pkg::STATUS_W-1:0] status;
        logic                          last;
    } sched_result_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic [ptts_pkg::OP_W-1:0]     opcode      = ptts_pkg::OP_TICK;
    logic [ptts_pkg::SLOT_W-1:0]   slot        = '0;
    logic [ptts_pkg::TIME_W-1:0]   period      = '0;
    logic [ptts_pkg::TIME_W-1:0]   first_delay = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic                          kind;
    logic [ptts_pkg::SLOT_W-1:0]   task_slot;
    logic [ptts_pkg::STATUS_W-1:0] status;
    logic                          last;

    // Shadow of the slot table
    logic                        tbl_present [ptts_pkg::SLOT_COUNT];
    logic                        tbl_resumed [ptts_pkg::SLOT_COUNT];
    logic [ptts_pkg::TIME_W-1:0] tbl_period  [ptts_pkg::SLOT_COUNT];
    logic [ptts_pkg::TIME_W-1:0] tbl_delay   [ptts_pkg::SLOT_COUNT];

    sched_result_t due_results [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;
    bit  hold_toggle    = 1'b0;
    bit  hold_seen      = 1'b0;

    periodic_task_tick_scheduler u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .task_slot   (task_slot),
        .status      (status),
        .last        (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < ptts_pkg::SLOT_COUNT; i++)
        begin
            tbl_present[i] = 1'b0;
            tbl_resumed[i] = 1'b0;
            tbl_period[i]  = '0;
            tbl_delay[i]   = '0;
        end
    end

    // Update the shadow table for one accepted transaction and queue what it should produce
    task automatic apply_to_slot_table(input logic [ptts_pkg::OP_W-1:0] op,
                                       input logic [ptts_pkg::SLOT_W-1:0] sl,
                                       input logic [ptts_pkg::TIME_W-1:0] per,
                                       input logic [ptts_pkg::TIME_W-1:0] fd);
        sched_result_t                   r;
        logic [ptts_pkg::SLOT_COUNT-1:0] fired;
        int                              n_fired;
        int                              top_fire;
        logic [ptts_pkg::STATUS_W-1:0]   st;
        fired    = '0;
        n_fired  = 0;
        top_fire = -1;
        st       = ptts_pkg::ST_OK;
        if (op == ptts_pkg::OP_TICK)
        begin
            for (int i = 0; i < ptts_pkg::SLOT_COUNT; i++)
            begin
                if (tbl_resumed[i])
                begin
                    if (tbl_delay[i] == '0)
                    begin
                        if (tbl_present[i] && n_fired < MAX_FIRES)
                        begin
                            fired[i]     = 1'b1;
                            n_fired++;
                            top_fire     = i;
                            tbl_delay[i] = tbl_period[i] - 1'b1;
                        end
                    end
                    else
                    begin
                        tbl_delay[i] = tbl_delay[i] - 1'b1;
                    end
                end
            end
            for (int i = 0; i < ptts_pkg::SLOT_COUNT; i++)
            begin
                if (fired[i])
                begin
                    r.kind      = ptts_pkg::KIND_FIRE;
                    r.task_slot = ptts_pkg::SLOT_W'(i);
                    r.status    = ptts_pkg::ST_OK;
                    r.last      = (i == top_fire);
                    due_results.push_back(r);
                end
            end
        end
        else if (op <= ptts_pkg::OP_DELETE)
        begin
            if (int'(sl) >= ptts_pkg::SLOT_COUNT)
            begin
                st = ptts_pkg::ST_RANGE;
            end
            else if (op == ptts_pkg::OP_CREATE)
            begin
                if (tbl_present[sl])
                begin
                    st = ptts_pkg::ST_TAKEN;
                end
                else
                begin
                    tbl_present[sl] = 1'b1;
                    tbl_resumed[sl] = 1'b1;
                    tbl_period[sl]  = per;
                    tbl_delay[sl]   = fd;
                end
            end
            else if (op == ptts_pkg::OP_SUSPEND)
            begin
                tbl_resumed[sl] = 1'b0;
            end
            else if (op == ptts_pkg::OP_RESUME)
            begin
                tbl_resumed[sl] = 1'b1;
            end
            else
            begin
                tbl_present[sl] = 1'b0;
            end
            r.kind      = ptts_pkg::KIND_STATUS;
            r.task_slot = sl;
            r.status    = st;
            r.last      = 1'b1;
            due_results.push_back(r);
        end
    endtask

    // Offer one transaction, idling beforehand at the current rate; valid is left high
    task automatic send_item(input logic [ptts_pkg::OP_W-1:0] op,
                             input logic [ptts_pkg::SLOT_W-1:0] sl,
                             input logic [ptts_pkg::TIME_W-1:0] per,
                             input logic [ptts_pkg::TIME_W-1:0] fd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        slot        <= sl;
        period      <= per;
        first_delay <= fd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_to_slot_table(op, sl, per, fd);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (ptts_pkg::SLOT_COUNT + 4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %s%0d %0d %0d %0d",
                         $time, "kind/slot/status/last ", kind, task_slot, status, last);
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("task_slot", want.task_slot, task_slot);
                check_field("status", want.status, status);
                check_field("last", want.last, last);
            end
        end
    end

    // Result side: random stalls, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_toggle)
        begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(ptts_pkg::OP_CREATE, 3'd0, 16'd1, 16'd0);
        send_item(ptts_pkg::OP_CREATE, 3'd0, 16'd5, 16'd5);         // slot taken
        send_item(ptts_pkg::OP_CREATE, 3'd7, 16'd0, 16'd0);         // zero period reloads all ones
        send_item(ptts_pkg::OP_CREATE, 3'd3, 16'hFFFF, 16'hFFFF);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF);
        send_item(ptts_pkg::OP_SUSPEND, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_RESUME, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        // resumed but empty, delay already zero: must stay quiet
        send_item(ptts_pkg::OP_DELETE, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        // an empty resumed slot still counts down
        send_item(ptts_pkg::OP_CREATE, 3'd4, 16'd3, 16'd2);
        send_item(ptts_pkg::OP_DELETE, 3'd4, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_SUSPEND, 3'd5, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_RESUME, 3'd5, 16'd0, 16'd0);
        send_item(ptts_pkg::OP_DELETE, 3'd5, 16'd0, 16'd0);
        // unknown opcodes: no response
        send_item(ptts_pkg::OP_DELETE + 3'd1, 3'd7, 16'hFFFF, 16'hFFFF);
        send_item(ptts_pkg::OP_DELETE + 3'd2, 3'd2, 16'h5555, 16'hAAAA);
        send_item(ptts_pkg::OP_DELETE + 3'd3, 3'd1, 16'hAAAA, 16'h5555);
        send_item(ptts_pkg::OP_CREATE, 3'd0, 16'd2, 16'd1);
        send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
        wait_for_results();
    endtask

    task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
        logic [ptts_pkg::OP_W-1:0]   op;
        logic [ptts_pkg::SLOT_W-1:0] sl;
        logic [ptts_pkg::TIME_W-1:0] per;
        logic [ptts_pkg::TIME_W-1:0] fd;
        int                          pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(99);
            sl   = ptts_pkg::SLOT_W'($urandom_range(0, (1 << ptts_pkg::SLOT_W) - 1));
            // keep periods and delays short so slots fire often
            per  = ($urandom_range(9) < 7) ? ptts_pkg::TIME_W'($urandom_range(0, 4))
                                           : ptts_pkg::TIME_W'($urandom_range(0, 65535));
            fd   = ($urandom_range(9) < 7) ? ptts_pkg::TIME_W'($urandom_range(0, 3))
                                           : ptts_pkg::TIME_W'($urandom_range(0, 65535));
            if (pick < 45)
                op = ptts_pkg::OP_TICK;
            else if (pick < 65)
                op = ptts_pkg::OP_CREATE;
            else if (pick < 73)
                op = ptts_pkg::OP_SUSPEND;
            else if (pick < 83)
                op = ptts_pkg::OP_RESUME;
            else if (pick < 95)
                op = ptts_pkg::OP_DELETE;
            else
                op = ptts_pkg::OP_W'($urandom_range(ptts_pkg::OP_DELETE + 1,
                                                    (1 << ptts_pkg::OP_W) - 1));
            send_item(op, sl, per, fd);
        end
        wait_for_results();
    endtask

    // Fill every slot, then hold the result side while ticks keep coming
    task automatic test_receiver_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int s = 0; s < ptts_pkg::SLOT_COUNT; s++)
            send_item(ptts_pkg::OP_DELETE, ptts_pkg::SLOT_W'(s), 16'd0, 16'd0);
        for (int s = 0; s < ptts_pkg::SLOT_COUNT; s++)
            send_item(ptts_pkg::OP_CREATE, ptts_pkg::SLOT_W'(s), 16'd1, 16'd0);
        hold_toggle = ~hold_toggle;
        for (int k = 0; k < 10; k++)
            send_item(ptts_pkg::OP_TICK, ptts_pkg::SLOT_W'($urandom_range(0, 7)),
                      ptts_pkg::TIME_W'($urandom), ptts_pkg::TIME_W'($urandom));
        wait_for_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_mix(45, 0, 0);
        test_random_mix(45, 63, 0);
        test_random_mix(45, 0, 63);
        test_random_mix(45, 35, 35);
        test_receiver_hold();
        if (due_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, due_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
